@@ sv/lra_pkg.sv @@
package lra_pkg;

  // operation codes carried on in_tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // direction of the line set up on load
  typedef struct packed {
    logic steep;      // major axis is y
    logic minor_dec;  // minor coordinate steps downward
  } lra_dir_t;

endpackage

@@ sv/lra_setup.sv @@
module lra_setup import lra_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0]        x_start,
  input  logic [COORD_BITS-1:0]        y_start,
  input  logic [COORD_BITS-1:0]        x_end,
  input  logic [COORD_BITS-1:0]        y_end,
  output lra_dir_t                     dir,
  output logic [COORD_BITS-1:0]        first_x,
  output logic [COORD_BITS-1:0]        first_y,
  output logic [COORD_BITS-1:0]        major_limit,
  output logic signed [COORD_BITS+2:0] decision,
  output logic [COORD_BITS:0]          inc_straight,
  output logic signed [COORD_BITS+1:0] inc_diagonal
);

  localparam int N = COORD_BITS;

  logic [N:0]   dx;
  logic [N:0]   dy;
  logic [N:0]   dx_neg;
  logic [N:0]   dy_neg;
  logic [N-1:0] adx;
  logic [N-1:0] ady;
  logic [N-1:0] amaj;
  logic [N-1:0] amin;
  logic         steep;
  logic         swap;
  logic [N:0]   amin_diff;

  // absolute deltas
  assign dx     = {1'b0, x_end} - {1'b0, x_start};
  assign dy     = {1'b0, y_end} - {1'b0, y_start};
  assign dx_neg = ~dx + {{N{1'b0}}, 1'b1};
  assign dy_neg = ~dy + {{N{1'b0}}, 1'b1};
  assign adx    = dx[N] ? dx_neg[N-1:0] : dx[N-1:0];
  assign ady    = dy[N] ? dy_neg[N-1:0] : dy[N-1:0];

  // major axis and endpoint order, ties keep the given order
  assign steep = ady > adx;
  assign swap  = steep ? (y_start > y_end) : (x_start > x_end);

  assign first_x     = swap ? x_end : x_start;
  assign first_y     = swap ? y_end : y_start;
  assign major_limit = steep ? (swap ? y_start : y_end) : (swap ? x_start : x_end);

  // minor step direction after ordering
  assign dir.steep     = steep;
  assign dir.minor_dec = steep ? (swap ? (x_start < x_end) : (x_end < x_start))
                               : (swap ? (y_start < y_end) : (y_end < y_start));

  // decision term and increments
  assign amaj      = steep ? ady : adx;
  assign amin      = steep ? adx : ady;
  assign amin_diff = {1'b0, amin} - {1'b0, amaj};

  assign inc_straight = {amin, 1'b0};
  assign inc_diagonal = signed'({amin_diff, 1'b0});
  assign decision     = signed'({2'b00, amin, 1'b0}) - signed'({3'b000, amaj});

endmodule

@@ sv/lra_core.sv @@
module lra_core import lra_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  logic                         op,
  input  lra_dir_t                     set_dir,
  input  logic [COORD_BITS-1:0]        set_x,
  input  logic [COORD_BITS-1:0]        set_y,
  input  logic [COORD_BITS-1:0]        set_limit,
  input  logic signed [COORD_BITS+2:0] set_decision,
  input  logic [COORD_BITS:0]          set_inc_straight,
  input  logic signed [COORD_BITS+1:0] set_inc_diagonal,
  output logic                         emit,
  output logic [COORD_BITS-1:0]        pix_x,
  output logic [COORD_BITS-1:0]        pix_y,
  output logic                         pix_last,
  output logic                         busy
);

  localparam int N  = COORD_BITS;
  localparam int DW = COORD_BITS + 3;

  logic                 busy_r,  busy_nxt;
  lra_dir_t             dir_r,   dir_nxt;
  logic [N-1:0]         x_r,     x_nxt;
  logic [N-1:0]         y_r,     y_nxt;
  logic [N-1:0]         limit_r, limit_nxt;
  logic signed [DW-1:0] dec_r,   dec_nxt;
  logic [N:0]           incs_r,  incs_nxt;
  logic signed [N+1:0]  incd_r,  incd_nxt;

  logic [N-1:0]         major;
  logic [N-1:0]         minor;
  logic [N-1:0]         major_inc;
  logic [N-1:0]         minor_adv;
  logic                 go_diag;
  logic signed [DW-1:0] dec_step;

  // current pixel and end test
  assign major    = dir_r.steep ? y_r : x_r;
  assign minor    = dir_r.steep ? x_r : y_r;
  assign pix_last = major >= limit_r;
  assign pix_x    = x_r;
  assign pix_y    = y_r;
  assign emit     = fire && (op == OP_STEP) && busy_r;
  assign busy     = busy_r;

  // one midpoint step
  assign go_diag   = !dec_r[DW-1] && (dec_r != '0);
  assign major_inc = major + {{(N-1){1'b0}}, 1'b1};
  assign minor_adv = !go_diag ? minor
                   : dir_r.minor_dec ? minor - {{(N-1){1'b0}}, 1'b1}
                                     : minor + {{(N-1){1'b0}}, 1'b1};
  assign dec_step  = go_diag ? DW'(incd_r) : signed'({1'b0, incs_r});

  // next state: load sets up, step advances or ends the line
  always_comb begin
    busy_nxt  = busy_r;
    dir_nxt   = dir_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    limit_nxt = limit_r;
    dec_nxt   = dec_r;
    incs_nxt  = incs_r;
    incd_nxt  = incd_r;
    if (fire && (op == OP_LOAD)) begin
      busy_nxt  = 1'b1;
      dir_nxt   = set_dir;
      x_nxt     = set_x;
      y_nxt     = set_y;
      limit_nxt = set_limit;
      dec_nxt   = set_decision;
      incs_nxt  = set_inc_straight;
      incd_nxt  = set_inc_diagonal;
    end else if (emit) begin
      if (pix_last) begin
        busy_nxt = 1'b0;
      end else begin
        x_nxt   = dir_r.steep ? minor_adv : major_inc;
        y_nxt   = dir_r.steep ? major_inc : minor_adv;
        dec_nxt = dec_r + dec_step;
      end
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      dir_r   <= '0;
      x_r     <= '0;
      y_r     <= '0;
      limit_r <= '0;
      dec_r   <= '0;
      incs_r  <= '0;
      incd_r  <= '0;
    end else begin
      busy_r  <= busy_nxt;
      dir_r   <= dir_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      limit_r <= limit_nxt;
      dec_r   <= dec_nxt;
      incs_r  <= incs_nxt;
      incd_r  <= incd_nxt;
    end
  end

endmodule

@@ sv/line_rasterizer_all_octants_unit.sv @@
// a step transaction waits in the input transaction register until processing moves,
//   then its pixel is registered in the result register that drives out_tdata
// throughput: one transaction per cycle, load or step, while the result register is
//   free or drains, with the decision add and end compare closing the step loop
// reset: synchronous active-low rst_n clears the handshake registers and the line
//   state, leaving no line active
module line_rasterizer_all_octants_unit import lra_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // x_start, y_start, x_end, y_end, zero fill
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]   in_tdata,
  // operation
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // pixel_x, pixel_y, zero fill
  output logic [((2*COORD_BITS+7)/8)*8-1:0]   out_tdata,
  // last_pixel
  output logic                                out_tlast
);

  localparam int N     = COORD_BITS;
  localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;

  logic         in_valid_r, in_valid_nxt;
  logic         in_op_r;
  logic [N-1:0] xs_r, ys_r, xe_r, ye_r;
  logic         out_valid_r, out_valid_nxt;
  logic [N-1:0] out_x_r, out_y_r;
  logic         out_last_r;

  logic                 in_fire;
  logic                 proc_fire;
  lra_dir_t             set_dir;
  logic [N-1:0]         set_x, set_y, set_limit;
  logic signed [N+2:0]  set_decision;
  logic [N:0]           set_inc_straight;
  logic signed [N+1:0]  set_inc_diagonal;
  logic                 emit;
  logic [N-1:0]         pix_x, pix_y;
  logic                 pix_last;
  logic                 busy;

  // handshake: processing moves when the result register is free or drains
  assign proc_fire = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc_fire;
  assign in_fire   = in_tvalid && in_tready;

  assign in_valid_nxt  = in_fire ? 1'b1 : (proc_fire ? 1'b0 : in_valid_r);
  assign out_valid_nxt = emit ? 1'b1 : ((out_valid_r && out_tready) ? 1'b0 : out_valid_r);

  // input transaction register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_op_r <= in_tuser;
      xs_r    <= in_tdata[N-1:0];
      ys_r    <= in_tdata[2*N-1:N];
      xe_r    <= in_tdata[3*N-1:2*N];
      ye_r    <= in_tdata[4*N-1:3*N];
    end
  end

  // line setup from the endpoints
  lra_setup #(.COORD_BITS(N)) u_setup (
    .x_start      (xs_r),
    .y_start      (ys_r),
    .x_end        (xe_r),
    .y_end        (ye_r),
    .dir          (set_dir),
    .first_x      (set_x),
    .first_y      (set_y),
    .major_limit  (set_limit),
    .decision     (set_decision),
    .inc_straight (set_inc_straight),
    .inc_diagonal (set_inc_diagonal)
  );

  // line state and stepping
  lra_core #(.COORD_BITS(N)) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .fire             (proc_fire),
    .op               (in_op_r),
    .set_dir          (set_dir),
    .set_x            (set_x),
    .set_y            (set_y),
    .set_limit        (set_limit),
    .set_decision     (set_decision),
    .set_inc_straight (set_inc_straight),
    .set_inc_diagonal (set_inc_diagonal),
    .emit             (emit),
    .pix_x            (pix_x),
    .pix_y            (pix_y),
    .pix_last         (pix_last),
    .busy             (busy)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x_r    <= pix_x;
      out_y_r    <= pix_y;
      out_last_r <= pix_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_y_r, out_x_r});
  assign out_tlast  = out_last_r;

  // a pixel only comes from an active line
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> busy)
    else $error("pixel emitted with no active line");

  // a load always leaves a line active
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && (in_op_r == OP_LOAD)) |=> busy)
    else $error("load did not start a line");

  // the flagged pixel ends the line, any other keeps it going
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && pix_last) |=> !busy)
    else $error("line still active after last pixel");

  a_mid_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !pix_last) |=> busy)
    else $error("line dropped before last pixel");

  // a new result is never written over one not yet taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

endmodule
